>>> hw/rtl/vmd_pkg.sv
// shared types and constants for the source-map mappings decoder
package vmd_pkg;

   // decoded value width and digit limit per value
   localparam int VALUE_BITS  = 32;
   localparam int DIGIT_LIMIT = (VALUE_BITS + 4) / 5;
   localparam int MAX_DIGITS  = (DIGIT_LIMIT > 12) ? 12 : DIGIT_LIMIT;
   localparam logic [5:0] SHIFT_LIMIT = 6'(5 * MAX_DIGITS);
   localparam logic [5:0] DIGIT_BITS  = 6'd5;

   // classified-item queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // base64 digit values
   localparam logic [7:0] DIGIT_LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_NUM_BASE   = 8'd52;
   localparam logic [5:0] DIGIT_PLUS       = 6'd62;
   localparam logic [5:0] DIGIT_SLASH      = 6'd63;

   // result kinds and error codes
   localparam logic       KIND_RECORD    = 1'b0;
   localparam logic       KIND_ERROR     = 1'b1;
   localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
   localparam logic [2:0] ERR_UNFINISHED = 3'd1;
   localparam logic [2:0] ERR_EMPTY_SEG  = 3'd2;
   localparam logic [2:0] ERR_BAD_COUNT  = 3'd3;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

   typedef logic [VALUE_BITS-1:0] acc_type;
   typedef logic [VALUE_BITS+4:0] acc_wide_type;

   typedef enum logic [1:0] {
      CLS_DIGIT,
      CLS_COMMA,
      CLS_SEMI,
      CLS_BAD
   } cls_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [2:0]        error_code;
      logic signed [31:0] gen_row;
      logic signed [31:0] gen_col;
      logic signed [31:0] source_index;
      logic signed [31:0] orig_row;
      logic signed [31:0] orig_col;
      logic signed [31:0] name_index;
   } rsp_type;

   // classified character as it travels from front to back
   typedef struct packed {
      cls_type    cls;
      logic [5:0] digit;
      logic       first;
      logic       last;
   } item_type;

endpackage

>>> hw/rtl/vmd_front.sv
// front end: classifies each incoming character into a queue item
module vmd_front
   import vmd_pkg::*;
(
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     queue_push,
   output item_type queue_item
);

   logic [7:0] c;
   logic [7:0] upper_d;
   logic [7:0] lower_d;
   logic [7:0] num_d;

   assign c       = req_data.char_code;
   assign upper_d = c - CHAR_UPPER_A;
   assign lower_d = c - CHAR_LOWER_A + DIGIT_LOWER_BASE;
   assign num_d   = c - CHAR_ZERO + DIGIT_NUM_BASE;

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      queue_item.first = req_data.first;
      queue_item.last  = req_data.last;
      queue_item.digit = '0;
      queue_item.cls   = CLS_BAD;
      if (c == CHAR_COMMA) begin
         queue_item.cls = CLS_COMMA;
      end else if (c == CHAR_SEMI) begin
         queue_item.cls = CLS_SEMI;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         queue_item.cls   = CLS_DIGIT;
         queue_item.digit = upper_d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         queue_item.cls   = CLS_DIGIT;
         queue_item.digit = lower_d[5:0];
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         queue_item.cls   = CLS_DIGIT;
         queue_item.digit = num_d[5:0];
      end else if (c == CHAR_PLUS) begin
         queue_item.cls   = CLS_DIGIT;
         queue_item.digit = DIGIT_PLUS;
      end else if (c == CHAR_SLASH) begin
         queue_item.cls   = CLS_DIGIT;
         queue_item.digit = DIGIT_SLASH;
      end
   end

endmodule

>>> hw/rtl/vmd_queue.sv
// short fifo of classified items between front and back
module vmd_queue
   import vmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   item_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/vmd_back.sv
// back end: vlq accumulation, running positions, segment checks, result register
module vmd_back
   import vmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef struct packed {
      logic       emit;
      logic       is_error;
      logic [2:0] code;
   } seg_end_type;

   function automatic seg_end_type seg_end(input logic in_value, input logic [2:0] n,
                                           input logic by_comma);
      seg_end_type r;
      r = '0;
      if (in_value) begin
         r.emit = 1'b1; r.is_error = 1'b1; r.code = ERR_UNFINISHED;
      end else if (n == 3'd0) begin
         if (by_comma) begin
            r.emit = 1'b1; r.is_error = 1'b1; r.code = ERR_EMPTY_SEG;
         end
      end else if (n == 3'd4 || n == 3'd5) begin
         r.emit = 1'b1;
      end else if (n != 3'd1) begin
         r.emit = 1'b1; r.is_error = 1'b1; r.code = ERR_BAD_COUNT;
      end
      return r;
   endfunction

   logic [31:0] row_ff, row_in, col_ff, col_in, src_ff, src_in;
   logic [31:0] orow_ff, orow_in, ocol_ff, ocol_in, name_ff, name_in;
   acc_type     acc_ff, acc_in, acc_new, acc_cur;
   logic [5:0]  shift_ff, shift_in, shift_cur;
   logic        in_value_ff, in_value_in;
   logic [2:0]  seg_values_ff, seg_values_in;
   logic        seg_nonempty_ff, seg_nonempty_in;
   logic        halted_ff, halted_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        out_free;
   logic        row_bump;
   logic [31:0] mag, delta;
   seg_end_type outcome;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign item_pop  = item_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a first flag starts the value from scratch
   assign acc_cur   = item.first ? '0 : acc_ff;
   assign shift_cur = item.first ? '0 : shift_ff;

   assign acc_new = acc_cur | acc_type'(acc_wide_type'(item.digit[4:0]) << shift_cur);
   assign mag     = 32'(acc_new >> 1);
   assign delta   = acc_new[0] ? (32'd0 - mag) : mag;

   always_comb begin
      row_in          = row_ff;
      col_in          = col_ff;
      src_in          = src_ff;
      orow_in         = orow_ff;
      ocol_in         = ocol_ff;
      name_in         = name_ff;
      acc_in          = acc_ff;
      shift_in        = shift_ff;
      in_value_in     = in_value_ff;
      seg_values_in   = seg_values_ff;
      seg_nonempty_in = seg_nonempty_ff;
      halted_in       = halted_ff;
      outcome         = '0;
      row_bump        = 1'b0;

      if (item.first) begin
         row_in = '0; col_in = '0; src_in = '0; orow_in = '0; ocol_in = '0; name_in = '0;
         acc_in = '0; shift_in = '0; in_value_in = 1'b0; seg_values_in = '0;
         seg_nonempty_in = 1'b0; halted_in = 1'b0;
      end

      if (!halted_in) begin
         case (item.cls)
            CLS_COMMA, CLS_SEMI: begin
               outcome = seg_end(in_value_in, seg_values_in, item.cls == CLS_COMMA);
               if (item.cls == CLS_SEMI && !outcome.is_error) begin
                  row_bump = 1'b1;
               end
            end
            CLS_DIGIT: begin
               if (shift_in >= SHIFT_LIMIT) begin
                  outcome = '{emit: 1'b1, is_error: 1'b1, code: ERR_TOO_LONG};
               end else begin
                  seg_nonempty_in = 1'b1;
                  if (item.digit[5]) begin
                     acc_in      = acc_new;
                     shift_in    = shift_in + DIGIT_BITS;
                     in_value_in = 1'b1;
                  end else begin
                     case (seg_values_in)
                        3'd0:    col_in  = col_in + delta;
                        3'd1:    src_in  = src_in + delta;
                        3'd2:    orow_in = orow_in + delta;
                        3'd3:    ocol_in = ocol_in + delta;
                        3'd4:    name_in = name_in + delta;
                        default: ;
                     endcase
                     if (seg_values_in != 3'd7) begin
                        seg_values_in = seg_values_in + 3'd1;
                     end
                     acc_in      = '0;
                     shift_in    = '0;
                     in_value_in = 1'b0;
                  end
                  // final byte flushes the open segment
                  if (item.last) begin
                     outcome = seg_end(in_value_in, seg_values_in, 1'b0);
                     acc_in = '0; shift_in = '0; in_value_in = 1'b0;
                     seg_values_in = '0; seg_nonempty_in = 1'b0;
                  end
               end
            end
            default: begin
               outcome = '{emit: 1'b1, is_error: 1'b1, code: ERR_BAD_CHAR};
            end
         endcase
         if (item.cls == CLS_COMMA || item.cls == CLS_SEMI || outcome.is_error) begin
            acc_in = '0; shift_in = '0; in_value_in = 1'b0;
            seg_values_in = '0; seg_nonempty_in = 1'b0;
         end
         if (outcome.is_error) begin
            halted_in = 1'b1;
         end
      end

      rsp_data_in = '0;
      if (outcome.is_error) begin
         rsp_data_in.kind       = KIND_ERROR;
         rsp_data_in.error_code = outcome.code;
      end else begin
         rsp_data_in.kind         = KIND_RECORD;
         rsp_data_in.gen_row      = $signed(row_in);
         rsp_data_in.gen_col      = $signed(col_in);
         rsp_data_in.source_index = $signed(src_in);
         rsp_data_in.orig_row     = $signed(orow_in);
         rsp_data_in.orig_col     = $signed(ocol_in);
         rsp_data_in.name_index   = $signed(name_in);
      end

      // a semicolon moves to the next generated row; the record it closes keeps the old row
      if (row_bump) begin
         row_in = row_in + 32'd1;
         col_in = '0;
      end

      if (item_pop && outcome.emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff          <= '0;
         col_ff          <= '0;
         src_ff          <= '0;
         orow_ff         <= '0;
         ocol_ff         <= '0;
         name_ff         <= '0;
         acc_ff          <= '0;
         shift_ff        <= '0;
         in_value_ff     <= 1'b0;
         seg_values_ff   <= '0;
         seg_nonempty_ff <= 1'b0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (item_pop) begin
            row_ff          <= row_in;
            col_ff          <= col_in;
            src_ff          <= src_in;
            orow_ff         <= orow_in;
            ocol_ff         <= ocol_in;
            name_ff         <= name_in;
            acc_ff          <= acc_in;
            shift_ff        <= shift_in;
            in_value_ff     <= in_value_in;
            seg_values_ff   <= seg_values_in;
            seg_nonempty_ff <= seg_nonempty_in;
            halted_ff       <= halted_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && outcome.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hw/rtl/vlq_mappings_decoder.sv
// top level of the source-map mappings decoder
// Decodes a source-map v3 mappings string fed one character per transfer. Each
// character goes through a classifier into a two-entry queue, and the back end
// takes one queued character per cycle, so with no stall on the result side the
// block sustains one character per clock. A character is written into a queue
// slot at its input transfer, and the result register is loaded when the back
// end pops it from the queue. The rate is set by the back end's update of the
// running positions, which each character may read and write. A result is held
// in a register while the receiver stalls; the queue keeps taking characters
// until it fills. Segments of four or five values give a mapping record with
// absolute positions; errors give one error report and then characters are
// dropped until the next first flag.
module vlq_mappings_decoder
   import vmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // front to queue
   logic     queue_full;
   logic     queue_push;
   item_type queue_item;

   // queue to back
   logic     back_valid;
   item_type back_item;
   logic     back_pop;

   // classify characters, stall only when the queue is full
   vmd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_item (queue_item)
   );

   // decouples input transfers from result stalls
   vmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (queue_item),
      .full      (queue_full),
      .pop_valid (back_valid),
      .pop_item  (back_item),
      .pop       (back_pop)
   );

   // value decode, running positions and the result register
   vmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item       (back_item),
      .item_pop   (back_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
